// ----- sv/process_scheduler_queue_macros.svh -----
// Assertion macros used by the checker psq_chk.
`ifndef PROCESS_SCHEDULER_QUEUE_MACROS_SVH
`define PROCESS_SCHEDULER_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PSQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/psq_pkg.sv -----
// ----------------------------------------------------------------------------
// psq_pkg
// Types, field widths and codes of the process scheduler queue.
// ----------------------------------------------------------------------------
package psq_pkg;

    localparam int PID_W    = 22;
    localparam int WORK_W   = 16;
    localparam int STATUS_W = 2;
    localparam int WCOUNT_W = 7;
    localparam int SLICE_W  = 8;
    localparam int POLICY_W = 2;
    localparam int CFG_W    = 8;

    localparam int DEFAULT_QUEUE_DEPTH = 64;

    localparam logic [POLICY_W-1:0] POLICY_FCFS = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_SJF  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_SRTF = 2'd2;
    localparam logic [POLICY_W-1:0] POLICY_RR   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_WORKING  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FINISHED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXPIRED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DENIED   = 2'd3;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_SLICE  = 1'b1;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

endpackage

// ----- sv/psq_req_if.sv -----
// ----------------------------------------------------------------------------
// psq_req_if
// Request channel: one run request per transaction.
// ----------------------------------------------------------------------------
interface psq_req_if;
    logic                       valid;
    logic                       ready;
    logic [psq_pkg::PID_W-1:0]  requester_pid;
    logic [psq_pkg::WORK_W-1:0] work_left;

    modport source (output valid, output requester_pid, output work_left, input ready);
    modport sink   (input valid, input requester_pid, input work_left, output ready);
endinterface

// ----- sv/psq_res_if.sv -----
// ----------------------------------------------------------------------------
// psq_res_if
// Result channel: scheduler state after each request.
// ----------------------------------------------------------------------------
interface psq_res_if;
    logic                         valid;
    logic                         ready;
    logic [psq_pkg::STATUS_W-1:0] status;
    logic                         dropped;
    logic                         cpu_idle;
    logic [psq_pkg::PID_W-1:0]    running_pid;
    logic [psq_pkg::WCOUNT_W-1:0] waiting_count;

    modport source (output valid, output status, output dropped, output cpu_idle,
                    output running_pid, output waiting_count, input ready);
    modport sink   (input valid, input status, input dropped, input cpu_idle,
                    input running_pid, input waiting_count, output ready);
endinterface

// ----- sv/psq_ram.sv -----
// ----------------------------------------------------------------------------
// psq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module psq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sv/process_scheduler_queue.sv -----
// A request for the running process passes S_EXEC1, S_EXEC2 and S_FIN; when the
// queue head is loaded as new holder, S_HEAD_RD and S_HEAD_WAIT come before S_FIN.
// A denied request first scans the queued entries in S_SRCH and S_SRCH_CMP, and
// under SJF/SRTF an insertion sort through the S_SORT_* states follows.
// One request at a time; ready only while idle, and a result not yet taken stalls it.
// Reset clears control state; queue RAM contents stay undefined, no clearing pass.
// ----------------------------------------------------------------------------
// process_scheduler_queue
// CPU scheduler with FCFS, SJF, SRTF and round robin policies over a wait
// queue held in a circular RAM, walked by a small sequencer.
// ----------------------------------------------------------------------------
module process_scheduler_queue #(
    parameter int QUEUE_DEPTH = psq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [psq_pkg::CFG_W-1:0] cfg_data,
    psq_req_if.sink                   req,
    psq_res_if.source                 res
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC1, S_EXEC2, S_HEAD_RD, S_HEAD_WAIT, S_SRCH, S_SRCH_CMP,
        S_SORT_I, S_SORT_KEY, S_SORT_J, S_SORT_CMP, S_FIN
    } state_t;

    state_t                          state_reg, state_next;
    logic [psq_pkg::PID_W-1:0]       pid_reg, pid_next;
    logic [psq_pkg::WORK_W-1:0]      work_reg, work_next;
    logic [psq_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic                            dropped_reg, dropped_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [AW-1:0]                   head_reg, head_next;
    logic [psq_pkg::PID_W-1:0]       holder_reg, holder_next;
    logic                            idle_reg, idle_next;
    logic [psq_pkg::SLICE_W-1:0]     slice_reg, slice_next;
    logic [psq_pkg::POLICY_W-1:0]    policy_reg, policy_next;
    logic [psq_pkg::SLICE_W-1:0]     slen_reg, slen_next;
    logic [CW-1:0]                   i_reg, i_next;
    logic [CW-1:0]                   j_reg, j_next;
    logic [psq_pkg::PID_W-1:0]       kpid_reg, kpid_next;
    logic [psq_pkg::WORK_W-1:0]      kwork_reg, kwork_next;
    logic                            pop_reg, pop_next;
    logic                            ovalid_reg, ovalid_next;
    logic [psq_pkg::STATUS_W-1:0]    ostatus_reg, ostatus_next;
    logic                            odropped_reg, odropped_next;
    logic                            oidle_reg, oidle_next;
    logic [psq_pkg::PID_W-1:0]       opid_reg, opid_next;
    logic [psq_pkg::WCOUNT_W-1:0]    ocount_reg, ocount_next;

    logic                            we_pid, we_work;
    logic [AW-1:0]                   wr_addr, rd_addr;
    logic [psq_pkg::PID_W-1:0]       wr_pid, rd_pid;
    logic [psq_pkg::WORK_W-1:0]      wr_work, rd_work;
    logic                            full;

    // logical queue position to RAM address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                            input logic [CW-1:0] l);
        logic [AW:0] s;
        s = {1'b0, head} + (AW+1)'(l);
        if (s >= (AW+1)'(QUEUE_DEPTH))
        begin
            s = s - (AW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign full = (count_reg >= CW'(QUEUE_DEPTH));

    psq_ram #(.WIDTH(psq_pkg::PID_W), .DEPTH(QUEUE_DEPTH)) u_pid_ram (
        .clk(clk), .we(we_pid), .wr_addr(wr_addr), .wr_data(wr_pid),
        .rd_addr(rd_addr), .rd_data(rd_pid)
    );

    psq_ram #(.WIDTH(psq_pkg::WORK_W), .DEPTH(QUEUE_DEPTH)) u_work_ram (
        .clk(clk), .we(we_work), .wr_addr(wr_addr), .wr_data(wr_work),
        .rd_addr(rd_addr), .rd_data(rd_work)
    );

    always_comb
    begin
        state_next    = state_reg;
        pid_next      = pid_reg;
        work_next     = work_reg;
        status_next   = status_reg;
        dropped_next  = dropped_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        holder_next   = holder_reg;
        idle_next     = idle_reg;
        slice_next    = slice_reg;
        policy_next   = policy_reg;
        slen_next     = slen_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        kpid_next     = kpid_reg;
        kwork_next    = kwork_reg;
        pop_next      = pop_reg;
        ovalid_next   = ovalid_reg;
        ostatus_next  = ostatus_reg;
        odropped_next = odropped_reg;
        oidle_next    = oidle_reg;
        opid_next     = opid_reg;
        ocount_next   = ocount_reg;
        we_pid        = 1'b0;
        we_work       = 1'b0;
        wr_addr       = phys(head_reg, count_reg);
        wr_pid        = pid_reg;
        wr_work       = work_reg;
        rd_addr       = head_reg;

        if (cfg_we)
        begin
            if (cfg_index == psq_pkg::REG_POLICY)
            begin
                policy_next = cfg_data[psq_pkg::POLICY_W-1:0];
            end
            else
            begin
                slen_next = cfg_data;
            end
        end

        if (ovalid_reg && res.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    pid_next     = req.requester_pid;
                    work_next    = req.work_left;
                    dropped_next = 1'b0;
                    state_next   = S_EXEC1;
                end
            end

            S_EXEC1:
            begin
                if (idle_reg)
                begin
                    idle_next   = 1'b0;
                    holder_next = pid_reg;
                    if (policy_reg == psq_pkg::POLICY_SRTF)
                    begin
                        if (full)
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            we_pid     = 1'b1;
                            we_work    = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
                state_next = S_EXEC2;
            end

            S_EXEC2:
            begin
                state_next = S_FIN;
                if (holder_reg == pid_reg)
                begin
                    if (work_reg == '0)
                    begin
                        status_next = psq_pkg::ST_FINISHED;
                        if (policy_reg == psq_pkg::POLICY_SRTF)
                        begin
                            // drop the head entry, new head runs but stays queued
                            if (count_reg <= CW'(1))
                            begin
                                count_next  = '0;
                                idle_next   = 1'b1;
                                holder_next = '0;
                                if (count_reg != '0)
                                begin
                                    head_next = phys(head_reg, CW'(1));
                                end
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                head_next  = phys(head_reg, CW'(1));
                                pop_next   = 1'b0;
                                state_next = S_HEAD_RD;
                            end
                        end
                        else
                        begin
                            if (policy_reg == psq_pkg::POLICY_RR)
                            begin
                                slice_next = '0;
                            end
                            if (count_reg == '0)
                            begin
                                idle_next   = 1'b1;
                                holder_next = '0;
                            end
                            else
                            begin
                                pop_next   = 1'b1;
                                state_next = S_HEAD_RD;
                            end
                        end
                    end
                    else
                    begin
                        status_next = psq_pkg::ST_WORKING;
                        if (policy_reg == psq_pkg::POLICY_SRTF)
                        begin
                            we_work = 1'b1;
                            wr_addr = head_reg;
                        end
                        else if (policy_reg == psq_pkg::POLICY_RR)
                        begin
                            if (slice_reg == slen_reg)
                            begin
                                slice_next  = '0;
                                status_next = psq_pkg::ST_EXPIRED;
                                if (count_reg == '0)
                                begin
                                    idle_next   = 1'b1;
                                    holder_next = '0;
                                end
                                else
                                begin
                                    pop_next   = 1'b1;
                                    state_next = S_HEAD_RD;
                                end
                            end
                            else
                            begin
                                slice_next = slice_reg + 8'd1;
                            end
                        end
                    end
                end
                else
                begin
                    status_next = psq_pkg::ST_DENIED;
                    i_next      = '0;
                    state_next  = S_SRCH;
                end
            end

            S_HEAD_RD:
            begin
                state_next = S_HEAD_WAIT;
            end

            S_HEAD_WAIT:
            begin
                holder_next = rd_pid;
                if (pop_reg)
                begin
                    head_next  = phys(head_reg, CW'(1));
                    count_next = count_reg - CW'(1);
                end
                state_next = S_FIN;
            end

            S_SRCH:
            begin
                if (i_reg == count_reg)
                begin
                    // not queued: push at the tail
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        we_pid     = 1'b1;
                        we_work    = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (policy_reg == psq_pkg::POLICY_SJF ||
                        policy_reg == psq_pkg::POLICY_SRTF)
                    begin
                        i_next     = CW'(1);
                        state_next = S_SORT_I;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    rd_addr    = phys(head_reg, i_reg);
                    state_next = S_SRCH_CMP;
                end
            end

            S_SRCH_CMP:
            begin
                if (rd_pid == pid_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_SRCH;
                end
            end

            // stable insertion sort by work, one RAM access per cycle
            S_SORT_I:
            begin
                if (i_reg >= count_reg)
                begin
                    if (policy_reg == psq_pkg::POLICY_SRTF && count_reg != '0)
                    begin
                        pop_next   = 1'b0;
                        state_next = S_HEAD_RD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    rd_addr    = phys(head_reg, i_reg);
                    state_next = S_SORT_KEY;
                end
            end

            S_SORT_KEY:
            begin
                kpid_next  = rd_pid;
                kwork_next = rd_work;
                j_next     = i_reg;
                state_next = S_SORT_J;
            end

            S_SORT_J:
            begin
                if (j_reg == '0)
                begin
                    we_pid     = 1'b1;
                    we_work    = 1'b1;
                    wr_addr    = head_reg;
                    wr_pid     = kpid_reg;
                    wr_work    = kwork_reg;
                    i_next     = i_reg + CW'(1);
                    state_next = S_SORT_I;
                end
                else
                begin
                    rd_addr    = phys(head_reg, j_reg - CW'(1));
                    state_next = S_SORT_CMP;
                end
            end

            S_SORT_CMP:
            begin
                we_pid  = 1'b1;
                we_work = 1'b1;
                wr_addr = phys(head_reg, j_reg);
                if (rd_work > kwork_reg)
                begin
                    wr_pid     = rd_pid;
                    wr_work    = rd_work;
                    j_next     = j_reg - CW'(1);
                    state_next = S_SORT_J;
                end
                else
                begin
                    wr_pid     = kpid_reg;
                    wr_work    = kwork_reg;
                    i_next     = i_reg + CW'(1);
                    state_next = S_SORT_I;
                end
            end

            S_FIN:
            begin
                if (!ovalid_reg || res.ready)
                begin
                    ovalid_next   = 1'b1;
                    ostatus_next  = status_reg;
                    odropped_next = dropped_reg;
                    oidle_next    = idle_reg;
                    opid_next     = idle_reg ? '0 : holder_reg;
                    ocount_next   = psq_pkg::WCOUNT_W'(count_reg);
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            holder_reg  <= '0;
            idle_reg    <= 1'b1;
            slice_reg   <= '0;
            policy_reg  <= psq_pkg::POLICY_FCFS;
            slen_reg    <= psq_pkg::SLICE_RESET;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            holder_reg  <= holder_next;
            idle_reg    <= idle_next;
            slice_reg   <= slice_next;
            policy_reg  <= policy_next;
            slen_reg    <= slen_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pid_reg      <= pid_next;
        work_reg     <= work_next;
        status_reg   <= status_next;
        dropped_reg  <= dropped_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        kpid_reg     <= kpid_next;
        kwork_reg    <= kwork_next;
        pop_reg      <= pop_next;
        ostatus_reg  <= ostatus_next;
        odropped_reg <= odropped_next;
        oidle_reg    <= oidle_next;
        opid_reg     <= opid_next;
        ocount_reg   <= ocount_next;
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign res.valid         = ovalid_reg;
    assign res.status        = ostatus_reg;
    assign res.dropped       = odropped_reg;
    assign res.cpu_idle      = oidle_reg;
    assign res.running_pid   = opid_reg;
    assign res.waiting_count = ocount_reg;

endmodule

// ----- sv/psq_chk.sv -----
// ----------------------------------------------------------------------------
// psq_chk
// Port-level checks of the process scheduler queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "process_scheduler_queue_macros.svh"

module psq_chk #(
    parameter int QUEUE_DEPTH = psq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [psq_pkg::STATUS_W-1:0] res_status,
    input logic                         res_dropped,
    input logic                         res_cpu_idle,
    input logic [psq_pkg::PID_W-1:0]    res_running_pid,
    input logic [psq_pkg::WCOUNT_W-1:0] res_waiting_count
);

    // one request in flight: a transaction blocks the next cycle
    `PSQ_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready)

    `PSQ_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_status))

    `PSQ_ASSERT_NOW(a_idle_pid_zero, clk, rst_n, res_valid && res_cpu_idle, res_running_pid == '0)

    // a denied push can only be dropped by a full queue, which then stays full
    `PSQ_ASSERT_NOW(a_drop_full, clk, rst_n, res_valid && res_dropped && res_status == psq_pkg::ST_DENIED, res_waiting_count == psq_pkg::WCOUNT_W'(QUEUE_DEPTH))

endmodule

bind process_scheduler_queue psq_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_psq_chk (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .res_valid(res.valid), .res_ready(res.ready),
    .res_status(res.status), .res_dropped(res.dropped),
    .res_cpu_idle(res.cpu_idle), .res_running_pid(res.running_pid),
    .res_waiting_count(res.waiting_count)
);

// ----- test/psq_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psq_checker
// Watches the request, result and register ports of the scheduler, keeps its
// own copy of the wait queue and holder state, and compares every result
// transaction field by field with the expected scheduler state.
// ----------------------------------------------------------------------------
module psq_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [psq_pkg::CFG_W-1:0]    cfg_data,
    psq_req_if                           req,
    psq_res_if                           res,
    output int                           errors,
    output int                           pending,
    output int                           n_checked,
    output int                           n_expired,
    output int                           n_dropped,
    output logic                         cpu_free,
    output logic [psq_pkg::PID_W-1:0]    holder
);

    localparam int DEPTH = psq_pkg::DEFAULT_QUEUE_DEPTH;

    typedef struct packed {
        logic [psq_pkg::STATUS_W-1:0] status;
        logic                         dropped;
        logic                         cpu_idle;
        logic [psq_pkg::PID_W-1:0]    running_pid;
        logic [psq_pkg::WCOUNT_W-1:0] waiting_count;
    } sched_state_t;

    logic [psq_pkg::PID_W-1:0]    q_pid [DEPTH];
    logic [psq_pkg::WORK_W-1:0]   q_work[DEPTH];
    int                           q_len;
    logic [psq_pkg::SLICE_W-1:0]  slice_cnt;
    logic [psq_pkg::POLICY_W-1:0] policy;
    logic [psq_pkg::SLICE_W-1:0]  slice_len;
    sched_state_t                 expected_states[$];

    function automatic logic enqueue(logic [psq_pkg::PID_W-1:0] p,
                                     logic [psq_pkg::WORK_W-1:0] w);
        if (q_len >= DEPTH)
            return 1'b1;
        q_pid[q_len]  = p;
        q_work[q_len] = w;
        q_len++;
        return 1'b0;
    endfunction

    function automatic logic [psq_pkg::PID_W-1:0] dequeue();
        logic [psq_pkg::PID_W-1:0] head;
        if (q_len == 0)
            return '0;
        head = q_pid[0];
        for (int i = 0; i + 1 < q_len; i++)
        begin
            q_pid[i]  = q_pid[i+1];
            q_work[i] = q_work[i+1];
        end
        q_len--;
        return head;
    endfunction

    function automatic void head_or_idle();
        if (q_len == 0)
        begin
            cpu_free = 1'b1;
            holder   = '0;
        end
        else
            holder = dequeue();
    endfunction

    function automatic sched_state_t schedule(logic [psq_pkg::PID_W-1:0] p,
                                              logic [psq_pkg::WORK_W-1:0] w);
        sched_state_t               e;
        logic                       drop;
        logic                       found;
        logic [psq_pkg::PID_W-1:0]  tp;
        logic [psq_pkg::WORK_W-1:0] tw;
        drop = 1'b0;
        if (cpu_free)
        begin
            cpu_free = 1'b0;
            holder   = p;
            if (policy == psq_pkg::POLICY_SRTF)
                drop = enqueue(p, w);
        end
        if (holder == p)
        begin
            if (w == 0)
            begin
                e.status = psq_pkg::ST_FINISHED;
                if (policy == psq_pkg::POLICY_SRTF)
                begin
                    void'(dequeue());
                    if (q_len == 0)
                    begin
                        cpu_free = 1'b1;
                        holder   = '0;
                    end
                    else
                        holder = q_pid[0];
                end
                else
                begin
                    if (policy == psq_pkg::POLICY_RR)
                        slice_cnt = '0;
                    head_or_idle();
                end
            end
            else
            begin
                e.status = psq_pkg::ST_WORKING;
                if (policy == psq_pkg::POLICY_SRTF)
                    q_work[0] = w;
                else if (policy == psq_pkg::POLICY_RR)
                begin
                    if (slice_cnt == slice_len)
                    begin
                        slice_cnt = '0;
                        head_or_idle();
                        e.status = psq_pkg::ST_EXPIRED;
                    end
                    else
                        slice_cnt = slice_cnt + 1'b1;
                end
            end
        end
        else
        begin
            e.status = psq_pkg::ST_DENIED;
            found = 1'b0;
            for (int i = 0; i < q_len; i++)
                if (q_pid[i] == p)
                    found = 1'b1;
            if (!found)
            begin
                drop = enqueue(p, w);
                if (policy == psq_pkg::POLICY_SJF || policy == psq_pkg::POLICY_SRTF)
                begin
                    // stable insertion sort on work
                    for (int i = 1; i < q_len; i++)
                        for (int j = i; j > 0 && q_work[j-1] > q_work[j]; j--)
                        begin
                            tw = q_work[j]; q_work[j] = q_work[j-1]; q_work[j-1] = tw;
                            tp = q_pid[j];  q_pid[j]  = q_pid[j-1];  q_pid[j-1]  = tp;
                        end
                    if (policy == psq_pkg::POLICY_SRTF && q_len > 0)
                        holder = q_pid[0];
                end
            end
        end
        e.dropped       = drop;
        e.cpu_idle      = cpu_free;
        e.running_pid   = cpu_free ? '0 : holder;
        e.waiting_count = psq_pkg::WCOUNT_W'(q_len);
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_state_t e;
        sched_state_t got;
        if (!rst_n)
        begin
            q_len     = 0;
            holder    = '0;
            cpu_free  = 1'b1;
            slice_cnt = '0;
            policy    = psq_pkg::POLICY_FCFS;
            slice_len = psq_pkg::SLICE_RESET;
            errors    = 0;
            pending   = 0;
            n_checked = 0;
            n_expired = 0;
            n_dropped = 0;
            expected_states.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == psq_pkg::REG_POLICY)
                    policy = cfg_data[psq_pkg::POLICY_W-1:0];
                else
                    slice_len = cfg_data[psq_pkg::SLICE_W-1:0];
            end
            if (req.valid && req.ready)
                expected_states.push_back(schedule(req.requester_pid, req.work_left));
            if (res.valid && res.ready)
            begin
                got = '{res.status, res.dropped, res.cpu_idle, res.running_pid,
                        res.waiting_count};
                if (expected_states.size() == 0)
                begin
                    $error("result transaction with no request outstanding");
                    errors++;
                end
                else
                begin
                    e = expected_states.pop_front();
                    n_checked++;
                    if (e.status == psq_pkg::ST_EXPIRED)
                        n_expired++;
                    if (e.dropped)
                        n_dropped++;
                    if (got.status !== e.status)
                    begin
                        $error("status: expected %0d, got %0d", e.status, got.status);
                        errors++;
                    end
                    if (got.dropped !== e.dropped)
                    begin
                        $error("dropped: expected %0d, got %0d", e.dropped, got.dropped);
                        errors++;
                    end
                    if (got.cpu_idle !== e.cpu_idle)
                    begin
                        $error("cpu_idle: expected %0d, got %0d", e.cpu_idle, got.cpu_idle);
                        errors++;
                    end
                    if (got.running_pid !== e.running_pid)
                    begin
                        $error("running_pid: expected %0h, got %0h",
                               e.running_pid, got.running_pid);
                        errors++;
                    end
                    if (got.waiting_count !== e.waiting_count)
                    begin
                        $error("waiting_count: expected %0d, got %0d",
                               e.waiting_count, got.waiting_count);
                        errors++;
                    end
                end
            end
            pending = expected_states.size();
        end
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives run requests into the scheduler under each policy and several slice
// lengths, with bursty requests, result back-pressure and one long stall.
// ----------------------------------------------------------------------------
module testbench;

    localparam int N_PHASES     = 10;
    localparam int PER_PHASE    = 93;
    localparam int SETTLE       = 600;
    localparam int WATCHDOG_MAX = 20000;

    localparam logic [psq_pkg::POLICY_W-1:0] PH_POLICY [N_PHASES] = '{
        psq_pkg::POLICY_FCFS, psq_pkg::POLICY_SJF, psq_pkg::POLICY_SRTF,
        psq_pkg::POLICY_RR, psq_pkg::POLICY_RR, psq_pkg::POLICY_RR,
        psq_pkg::POLICY_SJF, psq_pkg::POLICY_SRTF, psq_pkg::POLICY_FCFS,
        psq_pkg::POLICY_RR};
    localparam logic [psq_pkg::SLICE_W-1:0] PH_SLICE [N_PHASES] = '{
        8'd10, 8'd10, 8'd10, 8'd0, 8'd255, 8'd3, 8'd200, 8'd1, 8'd7, 8'd10};

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic                          cfg_index;
    logic [psq_pkg::CFG_W-1:0]     cfg_data;
    int                            errors, pending, n_checked, n_expired, n_dropped;
    logic                          cpu_free;
    logic [psq_pkg::PID_W-1:0]     holder;
    int                            burst_left;
    int                            stuck_cycles = 0;
    logic                          long_hold;

    psq_req_if req();
    psq_res_if res();

    process_scheduler_queue uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .req(req), .res(res)
    );

    psq_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .req(req), .res(res), .errors(errors),
        .pending(pending), .n_checked(n_checked), .n_expired(n_expired),
        .n_dropped(n_dropped), .cpu_free(cpu_free), .holder(holder)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles > WATCHDOG_MAX)
        begin
            $display("process_scheduler_queue test failed");
            $finish;
        end
    end

    // result receiver: stall pattern is chosen anew after a random span
    initial
    begin
        int mode;
        int span;
        bit hold_done;
        res.ready = 1'b0;
        mode      = 0;
        span      = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold && !hold_done)
            begin
                res.ready = 1'b0;
                repeat (400) @(negedge clk);
                hold_done = 1'b1;
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(50, 300);
            end
            span--;
            case (mode)
                0: res.ready = 1'b1;
                1: res.ready = ($urandom_range(0, 1) == 0);
                default: res.ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send(input logic [psq_pkg::PID_W-1:0] p,
                        input logic [psq_pkg::WORK_W-1:0] w);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                req.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        req.valid         = 1'b1;
        req.requester_pid = p;
        req.work_left     = w;
        do
            @(posedge clk);
        while (!(req.valid && req.ready));
        @(negedge clk);
        burst_left--;
    endtask

    task automatic write_reg(input logic idx, input logic [psq_pkg::CFG_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic drain();
        req.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic send_random();
        int                         r;
        logic [psq_pkg::PID_W-1:0]  p;
        logic [psq_pkg::WORK_W-1:0] w;
        case ($urandom_range(0, 5))
            0: w = '0;
            1: w = '1;
            2: w = psq_pkg::WORK_W'($urandom_range(1, 15));
            default: w = psq_pkg::WORK_W'($urandom());
        endcase
        r = $urandom_range(0, 99);
        if (r < 30 && !cpu_free)
        begin
            p = holder;
            w = ($urandom_range(0, 3) == 0) ? '0 : w;
        end
        else if (r < 36)
            p = psq_pkg::PID_W'($urandom());
        else
            p = psq_pkg::PID_W'(32'h100 + $urandom_range(0, 79));
        send(p, w);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = psq_pkg::REG_POLICY;
        cfg_data          = '0;
        req.valid         = 1'b0;
        req.requester_pid = '0;
        req.work_left     = '0;
        long_hold         = 1'b0;
        burst_left        = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, holder finishing, duplicate denial
        write_reg(psq_pkg::REG_POLICY, psq_pkg::CFG_W'(psq_pkg::POLICY_FCFS));
        write_reg(psq_pkg::REG_SLICE, 8'd10);
        send('1, '1);
        send('0, '0);
        send('0, 16'd5);
        send(22'h2AAAAA, 16'h5555);
        send('1, '0);
        send('0, '0);
        send(22'h155555, 16'hAAAA);
        send(22'h155555, 16'h0001);
        send(22'h155555, '0);
        send(22'h000001, '0);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain();
            write_reg(psq_pkg::REG_POLICY, psq_pkg::CFG_W'(PH_POLICY[ph]));
            write_reg(psq_pkg::REG_SLICE, PH_SLICE[ph]);
            if (ph == 1)
                long_hold = 1'b1;
            for (int i = 0; i < PER_PHASE; i++)
                send_random();
        end

        req.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("Checked %0d results over all four policies in %0d policy phases;",
                 n_checked, N_PHASES);
        $display("%0d slice expiries and %0d full-queue drops were seen.",
                 n_expired, n_dropped);
        if (errors == 0)
            $display("process_scheduler_queue test passed");
        else
            $display("process_scheduler_queue test failed");
        $finish;
    end

endmodule

// ----- process_scheduler_queue.f -----
+incdir+sv
sv/psq_pkg.sv
sv/psq_req_if.sv
sv/psq_res_if.sv
sv/psq_ram.sv
sv/process_scheduler_queue.sv
sv/psq_chk.sv
test/psq_checker.sv
test/testbench.sv
